>>> rtl/psd_pkg.sv
// shared types, constants and codes of the syn port scan detector
`default_nettype none
package psd_pkg;

    localparam int TABLE_ENTRIES   = 64;
    localparam int PORTS_PER_ENTRY = 32;
    localparam int ENT_AW          = $clog2(TABLE_ENTRIES);
    localparam int PIDX_W          = $clog2(PORTS_PER_ENTRY);
    localparam int PORT_AW         = ENT_AW + PIDX_W;
    localparam int PORT_DEPTH      = TABLE_ENTRIES * PORTS_PER_ENTRY;
    localparam int USED_W          = ENT_AW + 1;
    localparam int PCNT_W          = PIDX_W + 1;

    localparam logic [5:0]  THRESHOLD_RST = 6'd15;
    localparam logic [15:0] WINDOW_RST    = 16'd10;
    localparam logic [15:0] COOLDOWN_RST  = 16'd60;
    localparam logic [15:0] IDLE_RST      = 16'd300;

    typedef enum logic [1:0] {
        ST_IGNORED = 2'd0,
        ST_COUNTED = 2'd1,
        ST_DROPPED = 2'd2,
        ST_SWEEP   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WINDOW    = 2'd1,
        CFG_COOLDOWN  = 2'd2,
        CFG_IDLE      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        action;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic        syn_bit;
        logic        ack_bit;
        logic [31:0] now_seconds;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic       alert;
        logic [5:0] unique_ports;
        logic [6:0] evicted_count;
    } t_res;

    typedef struct packed {
        logic [5:0]  port_threshold;
        logic [15:0] window_seconds;
        logic [15:0] cooldown_seconds;
        logic [15:0] idle_seconds;
    } t_cfg;

    typedef struct packed {
        logic [31:0]       source;
        logic [31:0]       dest;
        logic [31:0]       window_start;
        logic [31:0]       last_alert;
        logic              has_alerted;
        logic [31:0]       idle_stamp;
        logic [PCNT_W-1:0] port_total;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              we;
        logic [ENT_AW-1:0] waddr;
        t_entry            wdata;
        logic [ENT_AW-1:0] raddr;
    } t_ent_req;

    typedef struct packed {
        logic               we;
        logic [PORT_AW-1:0] waddr;
        logic [15:0]        wdata;
        logic [PORT_AW-1:0] raddr;
    } t_port_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CK,
        S_PREP,
        S_PSCAN_RD,
        S_PSCAN_CK,
        S_UPDATE,
        S_SW_RD,
        S_SW_CK,
        S_MV_RD,
        S_MV_WR,
        S_PC_RD,
        S_PC_WR
    } t_state;

endpackage
`default_nettype wire

>>> rtl/syn_port_scan_detector_unit.sv
// top level: configuration registers, sequencer and the two state memories
//
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------
// item     | in        | i_start, o_busy            | i_in (t_in)
// result   | out       | o_res_valid strobe         | o_res (t_res)
// config   | in        | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one item at a time; a packet that is not syn without ack gives its result
// the cycle after start. a packet searches the entry table, then scans the stored
// ports of the pair; each step reads the entry or port memory, then checks the word.
// a sweep frees idle entries, moving the last entry and its port list into the slot.
// reset empties the table at once; the receiver cannot stall results.
`default_nettype none
module syn_port_scan_detector_unit import psd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire t_in        i_in,
    output logic            o_res_valid,
    output t_res            o_res,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    t_cfg        r_cfg;
    t_ent_req    ent_req;
    t_port_req   port_req;
    t_entry      ent_rdata;
    logic [15:0] port_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.port_threshold   <= THRESHOLD_RST;
            r_cfg.window_seconds   <= WINDOW_RST;
            r_cfg.cooldown_seconds <= COOLDOWN_RST;
            r_cfg.idle_seconds     <= IDLE_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_cfg.port_threshold   <= i_cfg_data[5:0];
                CFG_WINDOW:    r_cfg.window_seconds   <= i_cfg_data;
                CFG_COOLDOWN:  r_cfg.cooldown_seconds <= i_cfg_data;
                CFG_IDLE:      r_cfg.idle_seconds     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    psd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .o_busy       (o_busy),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res),
        .o_ent_req    (ent_req),
        .i_ent_rdata  (ent_rdata),
        .o_port_req   (port_req),
        .i_port_rdata (port_rdata)
    );

    psd_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_req.we),
        .i_waddr (ent_req.waddr),
        .i_wdata (ent_req.wdata),
        .i_raddr (ent_req.raddr),
        .o_rdata (ent_rdata)
    );

    psd_ram #(.WIDTH(16), .DEPTH(PORT_DEPTH)) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (port_req.we),
        .i_waddr (port_req.waddr),
        .i_wdata (port_req.wdata),
        .i_raddr (port_req.raddr),
        .o_rdata (port_rdata)
    );
endmodule
`default_nettype wire

>>> rtl/psd_ram.sv
// simple dual port ram, one write and one registered read per cycle
`default_nettype none
module psd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/psd_ctrl.sv
// sequencer: pair search, port list scan, update and idle sweep
`default_nettype none
module psd_ctrl import psd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_in   i_in,
    input  wire t_cfg  i_cfg,
    output logic       o_busy,
    output logic       o_res_valid,
    output t_res       o_res,
    output t_ent_req   o_ent_req,
    input  wire t_entry i_ent_rdata,
    output t_port_req  o_port_req,
    input  wire logic [15:0] i_port_rdata
);
    t_state            r_state, n_state;
    t_in               r_in, n_in;
    t_entry            r_ent, n_ent;
    logic [USED_W-1:0] r_used, n_used;
    logic [USED_W-1:0] r_cnt, n_cnt;
    logic [ENT_AW-1:0] r_idx, n_idx;
    logic [PCNT_W-1:0] r_pcnt, n_pcnt;
    logic              r_seen, n_seen;
    logic [6:0]        r_evict, n_evict;
    logic              r_res_valid, n_res_valid;
    t_res              r_res, n_res;

    logic [USED_W-1:0] last_idx;
    logic [31:0]       d_window, d_alert, d_idle;
    logic              do_store, do_alert;
    logic [PCNT_W-1:0] new_count;

    assign last_idx = r_used - USED_W'(1);
    assign d_window = r_in.now_seconds - r_ent.window_start;
    assign d_alert  = r_in.now_seconds - r_ent.last_alert;
    assign d_idle   = r_in.now_seconds - i_ent_rdata.idle_stamp;
    assign do_store = !r_seen && (r_ent.port_total < PCNT_W'(PORTS_PER_ENTRY));
    assign new_count = do_store ? r_ent.port_total + PCNT_W'(1) : r_ent.port_total;
    assign do_alert = (new_count >= i_cfg.port_threshold)
                      && (!r_ent.has_alerted || d_alert > {16'h0, i_cfg.cooldown_seconds});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_res_valid <= n_res_valid;
        end
        r_in    <= n_in;
        r_ent   <= n_ent;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_pcnt  <= n_pcnt;
        r_seen  <= n_seen;
        r_evict <= n_evict;
        r_res   <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_ent       = r_ent;
        n_used      = r_used;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pcnt      = r_pcnt;
        n_seen      = r_seen;
        n_evict     = r_evict;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_ent_req   = '0;
        o_port_req  = '0;
        o_ent_req.raddr  = r_cnt[ENT_AW-1:0];
        o_port_req.raddr = {r_idx, r_pcnt[PIDX_W-1:0]};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_in    = i_in;
                    n_cnt   = '0;
                    n_evict = '0;
                    if (i_in.action) begin
                        n_state = S_SW_RD;
                    end else if (!(i_in.syn_bit && !i_in.ack_bit)) begin
                        n_res_valid = 1'b1;
                        n_res       = '0;
                        n_res.status = ST_IGNORED;
                    end else begin
                        n_state = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                if (r_cnt >= r_used) begin
                    if (r_used >= USED_W'(TABLE_ENTRIES)) begin
                        n_res_valid  = 1'b1;
                        n_res        = '0;
                        n_res.status = ST_DROPPED;
                        n_state      = S_IDLE;
                    end else begin
                        // new entry goes at the end of the packed table
                        n_ent.source       = r_in.source_addr;
                        n_ent.dest         = r_in.dest_addr;
                        n_ent.window_start = r_in.now_seconds;
                        n_ent.last_alert   = '0;
                        n_ent.has_alerted  = 1'b0;
                        n_ent.port_total   = '0;
                        n_idx   = r_used[ENT_AW-1:0];
                        n_used  = r_used + USED_W'(1);
                        n_state = S_PREP;
                    end
                end else begin
                    n_state = S_SRCH_CK;
                end
            end
            S_SRCH_CK: begin
                if (i_ent_rdata.source == r_in.source_addr &&
                    i_ent_rdata.dest == r_in.dest_addr) begin
                    n_ent   = i_ent_rdata;
                    n_idx   = r_cnt[ENT_AW-1:0];
                    n_state = S_PREP;
                end else begin
                    n_cnt   = r_cnt + USED_W'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_PREP: begin
                n_ent.idle_stamp = r_in.now_seconds;
                if (d_window > {16'h0, i_cfg.window_seconds}) begin
                    n_ent.window_start = r_in.now_seconds;
                    n_ent.port_total   = '0;
                end
                n_pcnt  = '0;
                n_seen  = 1'b0;
                n_state = S_PSCAN_RD;
            end
            S_PSCAN_RD: begin
                if (r_pcnt >= r_ent.port_total) begin
                    n_state = S_UPDATE;
                end else begin
                    n_state = S_PSCAN_CK;
                end
            end
            S_PSCAN_CK: begin
                if (i_port_rdata == r_in.dest_port) begin
                    n_seen  = 1'b1;
                    n_state = S_UPDATE;
                end else begin
                    n_pcnt  = r_pcnt + PCNT_W'(1);
                    n_state = S_PSCAN_RD;
                end
            end
            S_UPDATE: begin
                o_port_req.we    = do_store;
                o_port_req.waddr = {r_idx, r_ent.port_total[PIDX_W-1:0]};
                o_port_req.wdata = r_in.dest_port;
                o_ent_req.we     = 1'b1;
                o_ent_req.waddr  = r_idx;
                o_ent_req.wdata  = r_ent;
                o_ent_req.wdata.port_total = new_count;
                if (do_alert) begin
                    o_ent_req.wdata.last_alert  = r_in.now_seconds;
                    o_ent_req.wdata.has_alerted = 1'b1;
                end
                n_res_valid        = 1'b1;
                n_res              = '0;
                n_res.status       = ST_COUNTED;
                n_res.alert        = do_alert;
                n_res.unique_ports = 6'(new_count);
                n_state            = S_IDLE;
            end
            S_SW_RD: begin
                if (r_cnt >= r_used) begin
                    n_res_valid         = 1'b1;
                    n_res               = '0;
                    n_res.status        = ST_SWEEP;
                    n_res.evicted_count = r_evict;
                    n_state             = S_IDLE;
                end else begin
                    n_state = S_SW_CK;
                end
            end
            S_SW_CK: begin
                if (d_idle > {16'h0, i_cfg.idle_seconds}) begin
                    if (r_cnt != last_idx) begin
                        n_state = S_MV_RD;
                    end else begin
                        n_used  = last_idx;
                        n_evict = r_evict + 7'd1;
                        n_state = S_SW_RD;
                    end
                end else begin
                    n_cnt   = r_cnt + USED_W'(1);
                    n_state = S_SW_RD;
                end
            end
            S_MV_RD: begin
                o_ent_req.raddr = last_idx[ENT_AW-1:0];
                n_state = S_MV_WR;
            end
            S_MV_WR: begin
                o_ent_req.we    = 1'b1;
                o_ent_req.waddr = r_cnt[ENT_AW-1:0];
                o_ent_req.wdata = i_ent_rdata;
                n_pcnt  = '0;
                n_state = S_PC_RD;
            end
            S_PC_RD: begin
                o_port_req.raddr = {last_idx[ENT_AW-1:0], r_pcnt[PIDX_W-1:0]};
                n_state = S_PC_WR;
            end
            S_PC_WR: begin
                // copy the last entry's port list into the freed slot
                o_port_req.we    = 1'b1;
                o_port_req.waddr = {r_cnt[ENT_AW-1:0], r_pcnt[PIDX_W-1:0]};
                o_port_req.wdata = i_port_rdata;
                if (r_pcnt == PCNT_W'(PORTS_PER_ENTRY - 1)) begin
                    n_used  = last_idx;
                    n_evict = r_evict + 7'd1;
                    n_state = S_SW_RD;
                end else begin
                    n_pcnt  = r_pcnt + PCNT_W'(1);
                    n_state = S_PC_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
endmodule
`default_nettype wire

>>> rtl/psd_checker.sv
// port level checks of the detector and their binding to the top level
`default_nettype none
module psd_checker import psd_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire t_in  i_in,
    input wire logic o_res_valid,
    input wire t_res o_res
);
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result strobe right after reset");

    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.action) |=> o_busy)
        else $error("sweep transfer did not make the block busy");

    a_sweep_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_SWEEP) |->
        (!o_res.alert && o_res.unique_ports == 6'd0))
        else $error("sweep result carries packet fields");

    a_packet_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_SWEEP) |-> (o_res.evicted_count == 7'd0))
        else $error("packet result carries an eviction count");

    a_counted_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_COUNTED) |->
        (o_res.unique_ports != 6'd0 && o_res.unique_ports <= 6'(PORTS_PER_ENTRY)))
        else $error("counted result has a port count out of range");
endmodule

bind syn_port_scan_detector_unit psd_checker u_psd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_in        (i_in),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
`default_nettype wire
